[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bdq_pkg.sv]
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int COUNT_W = 10;
   localparam int INDEX_W = 9;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_READ       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // Action codes 5 to 7 are legal on the port, so the field stays plain.
   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         in_x;
      logic [7:0]         in_y;
      logic [7:0]         in_symbol;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic [7:0]         out_x;
      logic [7:0]         out_y;
      logic [7:0]         out_symbol;
   } rsp_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] symbol;
   } entry_type;

   // Everything about a result except the entry data, which the memory supplies.
   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               read_ok;
   } rsp_meta_type;

endpackage

[rtl/core/bounded_deque_with_indexed_read_core.sv]
`timescale 1ns / 1ps

// Bounded double-ended list of position entries (x, y, symbol byte), kept in a
// ring of CAPACITY slots addressed from a head pointer. A command beat is taken
// on every clock edge where start is high and busy is low, and its result beat
// appears on rsp_item with rsp_valid high in the next cycle, for that one
// cycle only; the receiver cannot stall and must take each result as it comes.
// Commands can be issued every cycle while busy is low, so the sustained rate
// is one item per clock; each result is registered along with the read of the
// single synchronous entry memory. Busy is high only while reset is applied
// and for the first cycle after it. Every command gives exactly one result with
// a status, the count after the command and, for a successful read, the entry;
// pops and failed reads return zero entry fields. Counts above 1023 are shown
// modulo 1024. Slots that were never pushed are never readable, so the memory
// needs no clearing after reset.

module bounded_deque_with_indexed_read_core #(
   parameter int CAPACITY = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bdq_pkg::req_type  req_item,
   output logic              rsp_valid,
   output bdq_pkg::rsp_type  rsp_item
);

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                  busy_ff;
   logic                  accept;
   logic                  rsp_valid_ff;
   bdq_pkg::rsp_meta_type meta_in, meta_ff;

   logic                  wr_en, rd_en;
   logic [PTR_W-1:0]      wr_addr, rd_addr;
   bdq_pkg::entry_type    wr_data, rd_data;

   // Hold off commands through reset so the pointers settle first.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // Reset itself also raises busy, so no beat is taken in any reset cycle.
   assign busy   = busy_ff || reset;
   assign accept = start && !busy;

   bdq_ctrl #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .meta     (meta_in)
   );

   bdq_entry_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The status and count travel alongside the memory read so they line up
   // with the read data in the result cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

   always_comb begin
      rsp_item.status     = meta_ff.status;
      rsp_item.count      = meta_ff.count;
      rsp_item.out_x      = meta_ff.read_ok ? rd_data.x : 8'd0;
      rsp_item.out_y      = meta_ff.read_ok ? rd_data.y : 8'd0;
      rsp_item.out_symbol = meta_ff.read_ok ? rd_data.symbol : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/bdq_entry_ram.sv]
`timescale 1ns / 1ps

module bdq_entry_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  bdq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output bdq_pkg::entry_type  rd_data
);

   bdq_pkg::entry_type mem [DEPTH];
   bdq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bdq_ctrl.sv]
`timescale 1ns / 1ps

module bdq_ctrl #(
   parameter int CAPACITY = 512,
   parameter int PTR_W    = 9,
   parameter int CNT_W    = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  bdq_pkg::req_type       req_item,
   output logic                   wr_en,
   output logic [PTR_W-1:0]       wr_addr,
   output bdq_pkg::entry_type     wr_data,
   output logic                   rd_en,
   output logic [PTR_W-1:0]       rd_addr,
   output bdq_pkg::rsp_meta_type  meta
);

   localparam int CMP_W = (CNT_W > bdq_pkg::INDEX_W) ? CNT_W : bdq_pkg::INDEX_W;
   localparam int OUT_W = (CNT_W > bdq_pkg::COUNT_W) ? CNT_W : bdq_pkg::COUNT_W;
   localparam logic [PTR_W:0]   CAP_SUM  = (PTR_W + 1)'(CAPACITY);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             full, empty, in_range;
   logic [PTR_W-1:0] head_dec, head_inc, tail_slot, idx_slot;
   logic [PTR_W:0]   tail_sum, idx_sum;
   logic [CMP_W-1:0] idx_ext, cnt_ext;
   logic [OUT_W-1:0] count_wide;

   always_comb begin
      full     = (count_ff == FULL_CNT);
      empty    = (count_ff == '0);
      head_dec = (head_ff == '0) ? LAST_PTR : head_ff - PTR_W'(1);
      head_inc = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
      // The head stays below the capacity and the count does not exceed it, so one subtract wraps the sum.
      tail_sum  = {1'b0, head_ff} + {1'b0, count_ff[PTR_W-1:0]};
      tail_slot = (tail_sum >= CAP_SUM) ? PTR_W'(tail_sum - CAP_SUM) : tail_sum[PTR_W-1:0];
      idx_ext   = CMP_W'(req_item.read_index);
      cnt_ext   = CMP_W'(count_ff);
      in_range  = (idx_ext < cnt_ext);
      idx_sum   = {1'b0, head_ff} + {1'b0, idx_ext[PTR_W-1:0]};
      idx_slot  = (idx_sum >= CAP_SUM) ? PTR_W'(idx_sum - CAP_SUM) : idx_sum[PTR_W-1:0];
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_slot;
      wr_data      = '{x: req_item.in_x, y: req_item.in_y, symbol: req_item.in_symbol};
      rd_en        = 1'b0;
      rd_addr      = idx_slot;
      meta.status  = bdq_pkg::STAT_DONE;
      meta.read_ok = 1'b0;
      if (accept) begin
         case (req_item.action)
            bdq_pkg::ACT_PUSH_FRONT: begin
               if (full) begin
                  meta.status = bdq_pkg::STAT_FULL;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
               if (full) begin
                  meta.status = bdq_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            bdq_pkg::ACT_POP_FRONT: begin
               if (empty) begin
                  meta.status = bdq_pkg::STAT_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bdq_pkg::ACT_POP_BACK: begin
               if (empty) begin
                  meta.status = bdq_pkg::STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bdq_pkg::ACT_READ: begin
               if (in_range) begin
                  rd_en        = 1'b1;
                  meta.read_ok = 1'b1;
               end else begin
                  meta.status = bdq_pkg::STAT_RANGE;
               end
            end
            default: begin
            end
         endcase
      end
      count_wide = OUT_W'(count_in);
      meta.count = count_wide[bdq_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/bdq_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker #(
   parameter int CAPACITY = 512
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bdq_pkg::req_type  req_item,
   input logic              rsp_valid,
   input bdq_pkg::rsp_type  rsp_item
);

   localparam logic [bdq_pkg::COUNT_W-1:0] FULL_COUNT = bdq_pkg::COUNT_W'(CAPACITY);

   logic accept;
   logic data_zero;

   assign accept    = start && !busy;
   assign data_zero = (rsp_item.out_x == 8'd0) && (rsp_item.out_y == 8'd0) &&
                      (rsp_item.out_symbol == 8'd0);

   // Each command beat yields exactly one result beat, in the next cycle.
   `ASSERT_NEXT(a_rsp_follows_cmd, clock, reset, accept, rsp_valid, "missing result beat")
   `ASSERT_NEXT(a_no_stray_rsp, clock, reset, !accept, !rsp_valid, "result beat without command")
   // Only a successful read carries entry data.
   `ASSERT_NEXT(a_nonread_zero, clock, reset,
                accept && (req_item.action != bdq_pkg::ACT_READ), data_zero,
                "entry fields set on a non-read result")
   `ASSERT_SAME(a_empty_count, clock, reset,
                rsp_valid && (rsp_item.status == bdq_pkg::STAT_EMPTY), rsp_item.count == '0,
                "rejected pop with nonzero count")
   `ASSERT_SAME(a_full_count, clock, reset,
                rsp_valid && (rsp_item.status == bdq_pkg::STAT_FULL),
                rsp_item.count == FULL_COUNT, "rejected push below capacity")

endmodule

bind bounded_deque_with_indexed_read_core bdq_checker #(
   .CAPACITY (CAPACITY)
) u_bdq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
